### rtl/assert_macros.svh
// Assertion macros for the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property on a clock, disabled while reset is high.
`define WSA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Condition that must never be true.
`define WSA_NEVER(lbl, clk, rst, cond) \
   `WSA_ASSERT(lbl, clk, rst, !(cond))

`endif

### rtl/wsa_pkg.sv
// Shared types and constants of the slot pool allocator.
// No dependencies.
`default_nettype none

package wsa_pkg;

   localparam int DEF_POOL_SLOTS = 32;
   localparam logic [5:0] NULL_LINK = 6'd63;

   typedef enum logic [1:0] {
      FN_ALLOC = 2'd0,
      FN_FREE  = 2'd1,
      FN_READ  = 2'd2,
      FN_NOP   = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_FULL    = 3'd1,
      ST_RANGE   = 3'd2,
      ST_NONE    = 3'd3,
      ST_NOT_OCC = 3'd4
   } status_type;

   // which fields a response carries
   typedef enum logic [1:0] {
      RK_ZERO,
      RK_SLOT,
      RK_ALLOC,
      RK_READ
   } rsp_kind_type;

   typedef struct packed {
      logic         load;
      logic         rd_free;
      logic         walk_start;
      logic         walk_step;
      logic         rd_value;
      logic         alloc;
      logic         unlink;
      logic         relink;
      logic         respond;
      status_type   status;
      rsp_kind_type kind;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     range_bad;
      logic     free_empty;
      logic     used_empty;
      logic     hit;
      logic     walk_end;
   } stat_type;

endpackage

`default_nettype wire

### rtl/wsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module wsa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

### rtl/wsa_datapath.sv
// Datapath: list heads, walk registers, link and value RAMs, busy bits, response registers.
// Depends on wsa_pkg and wsa_ram.
`default_nettype none

module wsa_datapath #(
   parameter int POOL_SLOTS = wsa_pkg::DEF_POOL_SLOTS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire wsa_pkg::cmd_type cmd,
   output wsa_pkg::stat_type     stat,
   input  wire logic [1:0]       req_func,
   input  wire logic [5:0]       req_slot_index,
   input  wire logic [31:0]      req_watch_value,
   output logic      [2:0]       rsp_status,
   output logic      [5:0]       rsp_slot_out,
   output logic                  rsp_slot_in_use,
   output logic      [31:0]      rsp_value_out
);

   localparam int IDX_W = $clog2(POOL_SLOTS);
   localparam logic [5:0] POOL_N = 6'(POOL_SLOTS);
   localparam logic [5:0] LAST_STEP = 6'(POOL_SLOTS - 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_SLOTS - 1);

   // link value of an entry never written since reset
   function automatic logic [5:0] link_reset(input logic [IDX_W-1:0] a);
      logic [5:0] r;
      r = (a == LAST_IDX) ? wsa_pkg::NULL_LINK : 6'(a) + 6'd1;
      return r;
   endfunction

   logic [1:0]             func_ff;
   logic [5:0]             slot_ff;
   logic [31:0]            value_ff;
   logic [5:0]             free_head_ff, free_head_in;
   logic [5:0]             used_head_ff, used_head_in;
   logic [5:0]             cur_ff, cur_in;
   logic [5:0]             prev_ff, prev_in;
   logic [5:0]             steps_ff, steps_in;
   logic [POOL_SLOTS-1:0]  busy_ff, busy_in;
   logic [POOL_SLOTS-1:0]  link_valid_ff, link_valid_in;
   logic                   rd_valid_ff;
   logic [IDX_W-1:0]       rd_addr_ff;

   logic                   link_we, link_re;
   logic [IDX_W-1:0]       link_waddr, link_raddr;
   logic [5:0]             link_wdata, link_q, nxt;
   logic [31:0]            value_q;
   logic                   busy_bit;

   wsa_ram #(.WIDTH(6), .DEPTH(POOL_SLOTS)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_en   (link_re),
      .rd_addr (link_raddr),
      .rd_data (link_q)
   );

   wsa_ram #(.WIDTH(32), .DEPTH(POOL_SLOTS)) u_value_ram (
      .clock   (clock),
      .wr_en   (cmd.alloc),
      .wr_addr (free_head_ff[IDX_W-1:0]),
      .wr_data (value_ff),
      .rd_en   (cmd.rd_value),
      .rd_addr (slot_ff[IDX_W-1:0]),
      .rd_data (value_q)
   );

   assign nxt = rd_valid_ff ? link_q : link_reset(rd_addr_ff);
   assign busy_bit = busy_ff[slot_ff[IDX_W-1:0]];

   always_comb begin
      link_re    = cmd.rd_free | cmd.walk_start | cmd.walk_step;
      link_raddr = nxt[IDX_W-1:0];
      if (cmd.rd_free) begin
         link_raddr = free_head_ff[IDX_W-1:0];
      end else if (cmd.walk_start) begin
         link_raddr = used_head_ff[IDX_W-1:0];
      end

      link_we    = cmd.alloc | cmd.relink | (cmd.unlink && prev_ff != wsa_pkg::NULL_LINK);
      link_waddr = prev_ff[IDX_W-1:0];
      link_wdata = nxt;
      if (cmd.alloc) begin
         link_waddr = free_head_ff[IDX_W-1:0];
         link_wdata = used_head_ff;
      end else if (cmd.relink) begin
         link_waddr = cur_ff[IDX_W-1:0];
         link_wdata = free_head_ff;
      end

      link_valid_in = link_valid_ff;
      if (link_we) begin
         link_valid_in[link_waddr] = 1'b1;
      end

      free_head_in = free_head_ff;
      used_head_in = used_head_ff;
      busy_in      = busy_ff;
      if (cmd.alloc) begin
         free_head_in = nxt;
         used_head_in = free_head_ff;
         busy_in[free_head_ff[IDX_W-1:0]] = 1'b1;
      end
      if (cmd.unlink && prev_ff == wsa_pkg::NULL_LINK) begin
         used_head_in = nxt;
      end
      if (cmd.relink) begin
         free_head_in = cur_ff;
         busy_in[cur_ff[IDX_W-1:0]] = 1'b0;
      end

      cur_in   = cur_ff;
      prev_in  = prev_ff;
      steps_in = steps_ff;
      if (cmd.walk_start) begin
         cur_in   = used_head_ff;
         prev_in  = wsa_pkg::NULL_LINK;
         steps_in = '0;
      end else if (cmd.walk_step) begin
         cur_in   = nxt;
         prev_in  = cur_ff;
         steps_in = steps_ff + 6'd1;
      end
   end

   always_comb begin
      stat.func       = wsa_pkg::func_type'(func_ff);
      stat.range_bad  = slot_ff >= POOL_N;
      stat.free_empty = free_head_ff >= POOL_N;
      stat.used_empty = used_head_ff >= POOL_N;
      stat.hit        = cur_ff == slot_ff;
      stat.walk_end   = (steps_ff == LAST_STEP) || (nxt >= POOL_N);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff  <= '0;
         used_head_ff  <= wsa_pkg::NULL_LINK;
         busy_ff       <= '0;
         link_valid_ff <= '0;
      end else begin
         free_head_ff  <= free_head_in;
         used_head_ff  <= used_head_in;
         busy_ff       <= busy_in;
         link_valid_ff <= link_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         slot_ff  <= req_slot_index;
         value_ff <= req_watch_value;
      end
      cur_ff   <= cur_in;
      prev_ff  <= prev_in;
      steps_ff <= steps_in;
      if (link_re) begin
         rd_valid_ff <= link_valid_ff[link_raddr];
         rd_addr_ff  <= link_raddr;
      end
      if (cmd.respond) begin
         rsp_status      <= cmd.status;
         rsp_slot_in_use <= 1'b0;
         rsp_value_out   <= '0;
         unique case (cmd.kind)
            wsa_pkg::RK_ZERO:  rsp_slot_out <= '0;
            wsa_pkg::RK_SLOT:  rsp_slot_out <= slot_ff;
            wsa_pkg::RK_ALLOC: rsp_slot_out <= free_head_ff;
            wsa_pkg::RK_READ: begin
               rsp_slot_out    <= slot_ff;
               rsp_slot_in_use <= busy_bit;
               rsp_value_out   <= busy_bit ? value_q : 32'd0;
            end
            default:           rsp_slot_out <= '0;
         endcase
      end
   end

endmodule

`default_nettype wire

### rtl/wsa_controller.sv
// Controller state machine: sequences allocate, free (list walk) and read.
// Depends on wsa_pkg.
`default_nettype none

module wsa_controller (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   output logic                   rsp_strobe,
   output wsa_pkg::cmd_type       cmd,
   input  wire wsa_pkg::stat_type stat
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_ALLOC,
      S_READ,
      S_WALK,
      S_UNLINK,
      S_RELINK
   } state_type;

   state_type state_ff, state_in;

   assign busy = state_ff != S_IDLE;

   always_comb begin
      cmd      = '0;
      cmd.status = wsa_pkg::ST_OK;
      cmd.kind   = wsa_pkg::RK_ZERO;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load = start;
            if (start) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_IDLE;
            cmd.respond = 1'b1;
            unique case (stat.func)
               wsa_pkg::FN_ALLOC: begin
                  if (stat.free_empty) begin
                     cmd.status = wsa_pkg::ST_FULL;
                  end else begin
                     cmd.respond = 1'b0;
                     cmd.rd_free = 1'b1;
                     state_in    = S_ALLOC;
                  end
               end
               wsa_pkg::FN_FREE: begin
                  cmd.kind = wsa_pkg::RK_SLOT;
                  priority if (stat.range_bad) begin
                     cmd.status = wsa_pkg::ST_RANGE;
                  end else if (stat.used_empty) begin
                     cmd.status = wsa_pkg::ST_NONE;
                  end else begin
                     cmd.respond    = 1'b0;
                     cmd.walk_start = 1'b1;
                     state_in       = S_WALK;
                  end
               end
               wsa_pkg::FN_READ: begin
                  cmd.kind = wsa_pkg::RK_SLOT;
                  if (stat.range_bad) begin
                     cmd.status = wsa_pkg::ST_RANGE;
                  end else begin
                     cmd.respond  = 1'b0;
                     cmd.rd_value = 1'b1;
                     state_in     = S_READ;
                  end
               end
               default: ;
            endcase
         end
         S_ALLOC: begin
            cmd.alloc   = 1'b1;
            cmd.respond = 1'b1;
            cmd.kind    = wsa_pkg::RK_ALLOC;
            state_in    = S_IDLE;
         end
         S_READ: begin
            cmd.respond = 1'b1;
            cmd.kind    = wsa_pkg::RK_READ;
            state_in    = S_IDLE;
         end
         S_WALK: begin
            priority if (stat.hit) begin
               state_in = S_UNLINK;
            end else if (stat.walk_end) begin
               cmd.respond = 1'b1;
               cmd.kind    = wsa_pkg::RK_SLOT;
               cmd.status  = wsa_pkg::ST_NOT_OCC;
               state_in    = S_IDLE;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         S_UNLINK: begin
            cmd.unlink = 1'b1;
            state_in   = S_RELINK;
         end
         S_RELINK: begin
            cmd.relink  = 1'b1;
            cmd.respond = 1'b1;
            cmd.kind    = wsa_pkg::RK_SLOT;
            state_in    = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         rsp_strobe <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rsp_strobe <= cmd.respond;
      end
   end

endmodule

`default_nettype wire

### rtl/watch_slot_pool_allocator_unit.sv
// Top level of the slot pool allocator: controller plus datapath.
// Depends on wsa_pkg, wsa_controller, wsa_datapath.
`default_nettype none

// An item is taken when start is high and busy is low. Its one result
// appears on the rsp_ ports for a single cycle with rsp_strobe high and
// cannot be held off. Allocate and read raise the strobe after the states
// S_DISPATCH and then S_ALLOC or S_READ; an operation that fails its
// checks raises it from S_DISPATCH. Free walks the used list one link per
// cycle through the link RAM's read port, via S_DISPATCH and S_WALK and,
// if found, S_UNLINK and S_RELINK. One item is worked on at a time;
// a new one may be accepted in the cycle the strobe is shown.
// Reset needs no clearing pass: never-written link entries read as their
// reset value through per-entry valid bits.
module watch_slot_pool_allocator_unit #(
   parameter int POOL_SLOTS = wsa_pkg::DEF_POOL_SLOTS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_func,
   input  wire logic [5:0]  req_slot_index,
   input  wire logic [31:0] req_watch_value,
   output logic             rsp_strobe,
   output logic      [2:0]  rsp_status,
   output logic      [5:0]  rsp_slot_out,
   output logic             rsp_slot_in_use,
   output logic      [31:0] rsp_value_out
);

   wsa_pkg::cmd_type  cmd;
   wsa_pkg::stat_type stat;

   wsa_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .stat       (stat)
   );

   wsa_datapath #(.POOL_SLOTS(POOL_SLOTS)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_func        (req_func),
      .req_slot_index  (req_slot_index),
      .req_watch_value (req_watch_value),
      .rsp_status      (rsp_status),
      .rsp_slot_out    (rsp_slot_out),
      .rsp_slot_in_use (rsp_slot_in_use),
      .rsp_value_out   (rsp_value_out)
   );

endmodule

`default_nettype wire

### rtl/wsa_checker.sv
// Port-level checker for the slot pool allocator, bound to the top level.
// Depends on wsa_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module wsa_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_strobe,
   input wire logic [2:0]  rsp_status,
   input wire logic        rsp_slot_in_use,
   input wire logic [31:0] rsp_value_out
);

   logic fail_with_data;

   assign fail_with_data = rsp_status != wsa_pkg::ST_OK &&
                           (rsp_slot_in_use || rsp_value_out != 32'd0);

   `WSA_ASSERT(a_accept_busy, clock, reset, start && !busy |=> busy)
   `WSA_NEVER(a_strobe_idle, clock, reset, rsp_strobe && busy)
   `WSA_ASSERT(a_strobe_single, clock, reset, rsp_strobe |=> !rsp_strobe)
   `WSA_NEVER(a_fail_no_data, clock, reset, rsp_strobe && fail_with_data)

endmodule

bind watch_slot_pool_allocator_unit wsa_checker u_wsa_checker (.*);

`default_nettype wire
